// File: hdl/rca_pkg.sv
// Shared constants, codes and controller/datapath interface types for the rational ALU.
`timescale 1ns / 1ps
package rca_pkg;

    localparam int W  = 32;               // accumulator and operand value width
    localparam int M  = 2 * W + 1;        // magnitude width of double-width intermediates
    localparam int S  = M + 1;            // signed width of double-width intermediates
    localparam int KW = $clog2(M + 1);    // shared power-of-two count in the GCD
    localparam int CW = $clog2(M);        // division step counter

    localparam logic [M-1:0] RED_LIM = M'(1) << (W - 1);

    localparam int IN_TDATA_W  = 2 * W;
    localparam int OUT_TDATA_W = ((2 * W - 1 + 7) / 8) * 8;

    typedef logic [2:0] t_mode;
    localparam t_mode MODE_LOAD = 3'd0;
    localparam t_mode MODE_ADD  = 3'd1;
    localparam t_mode MODE_SUB  = 3'd2;
    localparam t_mode MODE_MUL  = 3'd3;
    localparam t_mode MODE_DIV  = 3'd4;
    localparam t_mode MODE_LT   = 3'd5;
    localparam t_mode MODE_EQ   = 3'd6;
    localparam t_mode MODE_NOP  = 3'd7;

    typedef enum logic [1:0] {
        PAIR_AN_OD,
        PAIR_AD_ON,
        PAIR_AD_OD,
        PAIR_AN_ON
    } t_pair;

    typedef enum logic [1:0] {
        DST_P0,
        DST_P1,
        DST_P2
    } t_dst;

    typedef enum logic [1:0] {
        SRC_OPERAND,
        SRC_SUM,
        SRC_DIFF,
        SRC_P0P1
    } t_src;

    typedef struct packed {
        logic  capture;
        logic  mul_go;
        t_pair mul_pair;
        t_dst  mul_dst;
        logic  red_start;
        t_src  red_src;
        logic  gcd_step;
        logic  div_start;
        logic  div_step;
        logic  op_save;
        logic  acc_save;
        logic  ans_lt;
        logic  ans_eq;
        logic  out_load;
        logic  out_ovf;
    } t_cmd;

    typedef struct packed {
        logic gcd_done;
        logic g_zero;
        logic fit;
    } t_sts;

endpackage

// File: hdl/rational_accumulator_alu.sv
// From the input transaction to a valid result: the unused mode goes straight to the finish
// state; otherwise each reduction takes a start step, binary-GCD steps on the magnitudes and
// restoring divider steps (none when the GCD is 0), so the time an item takes is set by the
// GCD loop and the bit-serial divider.
// One item is in work at a time; a new transaction is taken while a result waits.
// Reset (i_rst_n low, synchronous) clears the accumulator to 0/0 and the handshake state.
`timescale 1ns / 1ps
module rational_accumulator_alu import rca_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // operand_numerator, operand_denominator
    input  logic [2:0]             i_s_axis_tuser,  // mode
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,  // acc_num_out, acc_den_out, zero pad
    output logic [1:0]             o_m_axis_tuser   // answer, overflow
);

    t_cmd          w_cmd;
    t_sts          w_sts;
    logic [W-1:0]  w_out_num;
    logic [W-2:0]  w_out_den;
    logic          w_out_ans, w_out_ovf;

    rca_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_mode    (i_s_axis_tuser),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    rca_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_in_num  (i_s_axis_tdata[W-1:0]),
        .i_in_den  (i_s_axis_tdata[2*W-1:W]),
        .o_sts     (w_sts),
        .o_out_num (w_out_num),
        .o_out_den (w_out_den),
        .o_out_ans (w_out_ans),
        .o_out_ovf (w_out_ovf)
    );

    assign o_m_axis_tdata = OUT_TDATA_W'({w_out_den, w_out_num});
    assign o_m_axis_tuser = {w_out_ovf, w_out_ans};

    // accepting a transaction always leaves idle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("ready held after an accepted transaction");

    // a test answer and an overflow never come together
    a_ans_ovf_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser[0] && o_m_axis_tuser[1]))
        else $error("answer and overflow both set");

    // GCD never steps once one operand reached zero
    a_gcd_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.gcd_step |-> !w_sts.gcd_done)
        else $error("GCD stepped after completion");

    // a result is loaded only while no input is being taken
    a_load_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !o_s_axis_tready)
        else $error("result loaded in idle");

endmodule

// File: hdl/rca_datapath.sv
// Datapath: operand and accumulator registers, shared multiplier, GCD and divider.
`timescale 1ns / 1ps
module rca_datapath import rca_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic [W-1:0]        i_in_num,
    input  logic [W-1:0]        i_in_den,
    output t_sts                o_sts,
    output logic [W-1:0]        o_out_num,
    output logic [W-2:0]        o_out_den,
    output logic                o_out_ans,
    output logic                o_out_ovf
);

    logic        [W-1:0]   r_in_num, r_in_den;
    logic signed [W-1:0]   r_acc_num;
    logic        [W-2:0]   r_acc_den;
    logic signed [W-1:0]   r_on;
    logic        [W-2:0]   r_od;
    logic signed [2*W-1:0] r_p0, r_p1, r_p2;
    logic        [M-1:0]   r_un, r_ud, r_ga, r_gb, r_g, r_qn, r_qd;
    logic        [M:0]     r_rn, r_rd;
    logic        [KW-1:0]  r_k;
    logic                  r_neg;
    logic                  r_ans;
    logic        [W-1:0]   r_out_num;
    logic        [W-2:0]   r_out_den;
    logic                  r_out_ans, r_out_ovf;

    logic signed [W-1:0]   w_ma, w_mb;
    logic signed [2*W-1:0] w_prod;
    logic signed [S-1:0]   w_n_in, w_d_in;
    logic        [M-1:0]   w_n_mag, w_d_mag;
    logic        [M:0]     w_rem_n, w_rem_d, w_gx;
    logic                  w_ge_n, w_ge_d;
    logic                  w_neg_eff, w_fit;
    logic        [M-1:0]   w_qn_neg;
    logic        [W-1:0]   w_res_num;

    // shared multiplier operand select
    always_comb begin
        case (i_cmd.mul_pair)
            PAIR_AN_OD: begin w_ma = r_acc_num;                 w_mb = $signed({1'b0, r_od}); end
            PAIR_AD_ON: begin w_ma = $signed({1'b0, r_acc_den}); w_mb = r_on; end
            PAIR_AD_OD: begin w_ma = $signed({1'b0, r_acc_den}); w_mb = $signed({1'b0, r_od}); end
            default:    begin w_ma = r_acc_num;                 w_mb = r_on; end
        endcase
    end
    assign w_prod = (2*W)'(w_ma) * (2*W)'(w_mb);

    // reduction source select
    always_comb begin
        case (i_cmd.red_src)
            SRC_OPERAND: begin
                w_n_in = S'($signed(r_in_num));
                w_d_in = S'($signed(r_in_den));
            end
            SRC_SUM: begin
                w_n_in = S'(r_p0) + S'(r_p1);
                w_d_in = S'(r_p2);
            end
            SRC_DIFF: begin
                w_n_in = S'(r_p0) - S'(r_p1);
                w_d_in = S'(r_p2);
            end
            default: begin
                w_n_in = S'(r_p0);
                w_d_in = S'(r_p1);
            end
        endcase
    end
    assign w_n_mag = w_n_in[S-1] ? M'(-w_n_in) : M'(w_n_in);
    assign w_d_mag = w_d_in[S-1] ? M'(-w_d_in) : M'(w_d_in);

    // restoring division step, both quotients in parallel
    assign w_gx    = {1'b0, r_g};
    assign w_rem_n = {r_rn[M-1:0], r_qn[M-1]};
    assign w_rem_d = {r_rd[M-1:0], r_qd[M-1]};
    assign w_ge_n  = (w_rem_n >= w_gx);
    assign w_ge_d  = (w_rem_d >= w_gx);

    assign w_neg_eff = r_neg && (r_qn != '0);
    assign w_fit     = (r_qd <= RED_LIM - M'(1)) &&
                       (w_neg_eff ? (r_qn <= RED_LIM) : (r_qn <= RED_LIM - M'(1)));
    assign w_qn_neg  = -r_qn;
    assign w_res_num = w_neg_eff ? w_qn_neg[W-1:0] : r_qn[W-1:0];

    assign o_sts.gcd_done = (r_ga == '0) || (r_gb == '0);
    assign o_sts.g_zero   = (r_g == '0);
    assign o_sts.fit      = w_fit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_num <= '0;
            r_acc_den <= '0;
        end else if (i_cmd.acc_save) begin
            r_acc_num <= w_res_num;
            r_acc_den <= r_qd[W-2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_num <= i_in_num;
            r_in_den <= i_in_den;
        end
        if (i_cmd.op_save) begin
            r_on <= w_res_num;
            r_od <= r_qd[W-2:0];
        end
        if (i_cmd.mul_go) begin
            case (i_cmd.mul_dst)
                DST_P0:  r_p0 <= w_prod;
                DST_P1:  r_p1 <= w_prod;
                default: r_p2 <= w_prod;
            endcase
        end
        if (i_cmd.red_start) begin
            r_un  <= w_n_mag;
            r_ud  <= w_d_mag;
            r_ga  <= w_n_mag;
            r_gb  <= w_d_mag;
            r_k   <= '0;
            r_neg <= (w_n_in[S-1] != w_d_in[S-1]);
        end else if (i_cmd.gcd_step) begin
            // binary GCD: strip shared twos, halve a lone even value, then subtract smaller from larger
            if (!r_ga[0] && !r_gb[0]) begin
                r_ga <= r_ga >> 1;
                r_gb <= r_gb >> 1;
                r_k  <= r_k + KW'(1);
            end else if (!r_ga[0]) begin
                r_ga <= r_ga >> 1;
            end else if (!r_gb[0]) begin
                r_gb <= r_gb >> 1;
            end else if (r_ga >= r_gb) begin
                r_ga <= r_ga - r_gb;
            end else begin
                r_gb <= r_gb - r_ga;
            end
        end
        if (i_cmd.div_start) begin
            r_g  <= (r_ga | r_gb) << r_k;
            r_qn <= r_un;
            r_qd <= r_ud;
            r_rn <= '0;
            r_rd <= '0;
        end else if (i_cmd.div_step) begin
            r_rn <= w_ge_n ? w_rem_n - w_gx : w_rem_n;
            r_rd <= w_ge_d ? w_rem_d - w_gx : w_rem_d;
            r_qn <= {r_qn[M-2:0], w_ge_n};
            r_qd <= {r_qd[M-2:0], w_ge_d};
        end
        if (i_cmd.capture) begin
            r_ans <= 1'b0;
        end else if (i_cmd.ans_lt) begin
            r_ans <= (r_p0 < r_p1);
        end else if (i_cmd.ans_eq) begin
            r_ans <= (r_acc_den != '0) && (r_od != '0) &&
                     (r_acc_den == r_od) && (r_acc_num == r_on);
        end
        if (i_cmd.out_load) begin
            r_out_num <= r_acc_num;
            r_out_den <= r_acc_den;
            r_out_ans <= r_ans;
            r_out_ovf <= i_cmd.out_ovf;
        end
    end

    assign o_out_num = r_out_num;
    assign o_out_den = r_out_den;
    assign o_out_ans = r_out_ans;
    assign o_out_ovf = r_out_ovf;

endmodule

// File: hdl/rca_ctrl.sv
// Controller: sequences operand reduction, products, result reduction and output transaction.
`timescale 1ns / 1ps
module rca_ctrl import rca_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_valid,
    input  t_mode i_mode,
    output logic  o_s_ready,
    output logic  o_m_valid,
    input  logic  i_m_ready,
    input  t_sts  i_sts,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_GCD,
        S_DIV,
        S_CHECK,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_RES,
        S_FINISH
    } t_state;

    t_state        r_state;
    t_mode         r_mode;
    logic [CW-1:0] r_cnt;
    logic          r_phase_op;
    logic          r_ovf;
    logic          r_out_valid;

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: o_cmd.capture = i_s_valid;
            S_START: begin
                o_cmd.red_start = 1'b1;
                o_cmd.red_src   = SRC_OPERAND;
            end
            S_GCD: begin
                o_cmd.div_start = i_sts.gcd_done;
                o_cmd.gcd_step  = !i_sts.gcd_done;
            end
            S_DIV: o_cmd.div_step = !i_sts.g_zero;
            S_CHECK: begin
                if (r_phase_op) begin
                    o_cmd.op_save  = i_sts.fit;
                    o_cmd.acc_save = i_sts.fit && (r_mode == MODE_LOAD);
                end else begin
                    o_cmd.acc_save = i_sts.fit;
                end
            end
            S_MUL0: begin
                if (r_mode == MODE_EQ) begin
                    o_cmd.ans_eq = 1'b1;
                end else begin
                    o_cmd.mul_go   = 1'b1;
                    o_cmd.mul_pair = (r_mode == MODE_MUL) ? PAIR_AN_ON : PAIR_AN_OD;
                    o_cmd.mul_dst  = DST_P0;
                end
            end
            S_MUL1: begin
                o_cmd.mul_go   = 1'b1;
                o_cmd.mul_pair = (r_mode == MODE_MUL) ? PAIR_AD_OD : PAIR_AD_ON;
                o_cmd.mul_dst  = DST_P1;
            end
            S_MUL2: begin
                o_cmd.mul_go   = 1'b1;
                o_cmd.mul_pair = PAIR_AD_OD;
                o_cmd.mul_dst  = DST_P2;
            end
            S_RES: begin
                if (r_mode == MODE_LT) begin
                    o_cmd.ans_lt = 1'b1;
                end else begin
                    o_cmd.red_start = 1'b1;
                    o_cmd.red_src   = (r_mode == MODE_ADD) ? SRC_SUM :
                                      (r_mode == MODE_SUB) ? SRC_DIFF : SRC_P0P1;
                end
            end
            S_FINISH: begin
                o_cmd.out_load = !r_out_valid || i_m_ready;
                o_cmd.out_ovf  = r_ovf;
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_NOP;
            r_cnt       <= '0;
            r_phase_op  <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_valid) begin
                        r_mode  <= i_mode;
                        r_ovf   <= 1'b0;
                        r_state <= (i_mode == MODE_NOP) ? S_FINISH : S_START;
                    end
                end
                S_START: begin
                    r_phase_op <= 1'b1;
                    r_state    <= S_GCD;
                end
                S_GCD: begin
                    if (i_sts.gcd_done) begin
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (i_sts.g_zero || r_cnt == CW'(M - 1)) begin
                        r_state <= S_CHECK;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_CHECK: begin
                    if (!i_sts.fit) begin
                        r_ovf   <= 1'b1;
                        r_state <= S_FINISH;
                    end else if (!r_phase_op || r_mode == MODE_LOAD) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_state <= S_MUL0;
                    end
                end
                S_MUL0: r_state <= (r_mode == MODE_EQ) ? S_FINISH : S_MUL1;
                S_MUL1: begin
                    r_state <= (r_mode == MODE_ADD || r_mode == MODE_SUB) ? S_MUL2 : S_RES;
                end
                S_MUL2: r_state <= S_RES;
                S_RES: begin
                    if (r_mode == MODE_LT) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_phase_op <= 1'b0;
                        r_state    <= S_GCD;
                    end
                end
                S_FINISH: begin
                    if (o_cmd.out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = r_out_valid;

endmodule
